FILE: src/sdf_pkg.sv
// Package with shared types and constants of the signed decimal formatter.
`timescale 1ns / 1ps
`default_nettype none

package sdf_pkg;

  localparam int unsigned OperandBits  = 64;
  localparam int unsigned CfgBits      = 7;
  localparam int unsigned CfgIdxBits   = 3;
  localparam int unsigned DigitCount   = 20;
  localparam int unsigned DigitBits    = 4 * DigitCount;
  localparam int unsigned LenBits      = 7;
  localparam int unsigned NdBits       = 5;
  localparam int unsigned MaxChars     = 64;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);
  localparam int unsigned ConvCntBits  = $clog2(OperandBits);

  localparam logic [CfgIdxBits-1:0] CfgOperandSize = 3'd0;
  localparam logic [CfgIdxBits-1:0] CfgFieldWidth  = 3'd1;
  localparam logic [CfgIdxBits-1:0] CfgMinDigits   = 3'd2;
  localparam logic [CfgIdxBits-1:0] CfgZeroPad     = 3'd3;
  localparam logic [CfgIdxBits-1:0] CfgPadRight    = 3'd4;
  localparam logic [CfgIdxBits-1:0] CfgSignMode    = 3'd5;

  localparam logic [1:0] Size8  = 2'd0;
  localparam logic [1:0] Size16 = 2'd1;
  localparam logic [1:0] Size32 = 2'd2;
  localparam logic [1:0] Size64 = 2'd3;

  localparam logic [1:0] SignNone  = 2'd0;
  localparam logic [1:0] SignPlus  = 2'd1;
  localparam logic [1:0] SignSpace = 2'd2;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSpace = 8'h20;

  typedef struct packed {
    logic [1:0]         operand_size;
    logic [CfgBits-1:0] field_width;
    logic [CfgBits-1:0] min_digits;
    logic               zero_pad;
    logic               pad_right;
    logic [1:0]         sign_mode;
  } cfg_t;

  typedef struct packed {
    logic                   neg;
    logic [OperandBits-1:0] mag;
  } entry_t;

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StCount,
    StLen,
    StPad,
    StBound,
    StEmit
  } back_state_e;

endpackage

`default_nettype wire

FILE: src/signed_decimal_formatter_top.sv
// Top level of the signed decimal formatter: configuration registers and stages.
//
// Channel   Direction  Beat contents
// s_axis    in         tdata[63:0] raw_value
// m_axis    out        tdata[7:0] out_char, tlast last_char
// cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i[6:0]
//
// In the back, an operand passes bit-serial binary to BCD conversion, then the digit
// count, length, padding and bound states before its first character. Characters
// leave one a cycle when the receiver is ready, up to 64, paced by the output register.
// The front and a two-entry queue take operands until full while the back is busy.
// Reset clears all control state; configuration comes back to its documented defaults.
`timescale 1ns / 1ps
`default_nettype none

module signed_decimal_formatter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // raw_value[63:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // out_char[7:0]
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [6:0]  cfg_data_i
);
  import sdf_pkg::*;

  cfg_t   cfg_q;
  logic   fq_valid;
  logic   fq_ready;
  entry_t fq_entry;
  logic   qb_valid;
  logic   qb_ready;
  entry_t qb_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.operand_size <= Size32;
      cfg_q.field_width  <= '0;
      cfg_q.min_digits   <= '1;
      cfg_q.zero_pad     <= 1'b0;
      cfg_q.pad_right    <= 1'b0;
      cfg_q.sign_mode    <= SignNone;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgOperandSize: cfg_q.operand_size <= cfg_data_i[1:0];
        CfgFieldWidth:  cfg_q.field_width  <= cfg_data_i;
        CfgMinDigits:   cfg_q.min_digits   <= cfg_data_i;
        CfgZeroPad:     cfg_q.zero_pad     <= cfg_data_i[0];
        CfgPadRight:    cfg_q.pad_right    <= cfg_data_i[0];
        CfgSignMode:    cfg_q.sign_mode    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  sdf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .operand_size_i (cfg_q.operand_size),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .in_data_i      (s_axis_tdata),
    .out_valid_o    (fq_valid),
    .out_ready_i    (fq_ready),
    .out_entry_o    (fq_entry)
  );

  sdf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_entry_i (fq_entry),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_entry_o  (qb_entry)
  );

  sdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (qb_valid),
    .in_ready_o  (qb_ready),
    .in_entry_i  (qb_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: src/sdf_front.sv
// Front stage: sign-extends the operand and registers its sign and magnitude.
`timescale 1ns / 1ps
`default_nettype none

module sdf_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [1:0]                     operand_size_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [sdf_pkg::OperandBits-1:0] in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output sdf_pkg::entry_t                     out_entry_o
);
  import sdf_pkg::*;

  logic                   valid_q;
  entry_t                 entry_q;
  entry_t                 entry_d;
  logic [OperandBits-1:0] ext;

  always_comb begin
    unique case (operand_size_i)
      Size8:   ext = {{(OperandBits-8){in_data_i[7]}}, in_data_i[7:0]};
      Size16:  ext = {{(OperandBits-16){in_data_i[15]}}, in_data_i[15:0]};
      Size32:  ext = {{(OperandBits-32){in_data_i[31]}}, in_data_i[31:0]};
      default: ext = in_data_i;
    endcase
    entry_d.neg = ext[OperandBits-1];
    entry_d.mag = ext[OperandBits-1] ? (~ext + {{(OperandBits-1){1'b0}}, 1'b1}) : ext;
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_entry_o = entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      entry_q <= entry_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/sdf_queue.sv
// Short queue of classified operands between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module sdf_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire sdf_pkg::entry_t push_entry_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output sdf_pkg::entry_t      pop_entry_o
);
  import sdf_pkg::*;

  entry_t                  mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q;
  logic [QueuePtrBits-1:0] rd_ptr_q;
  logic [QueuePtrBits:0]   count_q;
  logic                    push;
  logic                    pop;

  assign push_ready_o = count_q != (QueuePtrBits+1)'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_entry_o  = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/sdf_back.sv
// Back stage: binary to BCD conversion, field layout and character output.
`timescale 1ns / 1ps
`default_nettype none

module sdf_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sdf_pkg::cfg_t   cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire sdf_pkg::entry_t in_entry_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_char_o,
  output logic                 out_last_o
);
  import sdf_pkg::*;

  back_state_e                state_q, state_d;
  logic [ConvCntBits-1:0]     cnt_q, cnt_d;
  logic [OperandBits-1:0]     bin_q, bin_d;
  logic [DigitCount-1:0][3:0] bcd_q, bcd_d;
  logic [DigitCount-1:0][3:0] adj;
  logic [DigitBits-1:0]       adj_flat;
  logic                       neg_q, neg_d;
  logic [NdBits-1:0]          nd_q, nd_d;
  logic [LenBits-1:0]         nzero_q, nzero_d;
  logic [LenBits-1:0]         pad_q, pad_d;
  logic [LenBits-1:0]         b1_q, b1_d, b2_q, b2_d, b3_q, b3_d, b4_q, b4_d;
  logic [LenBits-1:0]         len_q, len_d;
  logic [LenBits-1:0]         pos_q, pos_d;
  logic                       ovalid_q, ovalid_d;
  logic [7:0]                 ochar_q, ochar_d;
  logic                       olast_q, olast_d;

  logic                       has_sign;
  logic [7:0]                 sign_char;
  logic                       prec_given;
  logic [LenBits-1:0]         prec_eff;
  logic [LenBits-1:0]         nd_ext;
  logic [LenBits-1:0]         body;
  logic [LenBits-1:0]         width_sat;
  logic [LenBits-1:0]         lead, zeros, trail;
  logic [LenBits-1:0]         sign_len;
  logic [LenBits-1:0]         dig_idx;
  logic                       out_free;

  always_comb begin
    for (int i = 0; i < DigitCount; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
    adj_flat = adj;
  end

  assign has_sign   = neg_q || cfg_i.sign_mode == SignPlus || cfg_i.sign_mode == SignSpace;
  assign sign_char  = neg_q ? CharMinus : ((cfg_i.sign_mode == SignPlus) ? CharPlus : CharSpace);
  assign sign_len   = {{(LenBits-1){1'b0}}, has_sign};
  assign prec_given = !cfg_i.min_digits[CfgBits-1];
  assign prec_eff   = prec_given ? {1'b0, cfg_i.min_digits[CfgBits-2:0]} : LenBits'(1);
  assign nd_ext     = LenBits'(nd_q);
  assign body       = sign_len + nzero_q + nd_ext;
  assign width_sat  = (cfg_i.field_width > LenBits'(MaxChars)) ? LenBits'(MaxChars)
                                                             : cfg_i.field_width;
  assign dig_idx    = b4_q - pos_q - LenBits'(1);
  assign out_free   = !ovalid_q || out_ready_i;

  always_comb begin
    if (cfg_i.pad_right) begin
      lead  = '0;
      zeros = nzero_q;
      trail = pad_q;
    end else if (cfg_i.zero_pad && !prec_given) begin
      lead  = '0;
      zeros = pad_q + nzero_q;
      trail = '0;
    end else begin
      lead  = pad_q;
      zeros = nzero_q;
      trail = '0;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    bin_d      = bin_q;
    bcd_d      = bcd_q;
    neg_d      = neg_q;
    nd_d       = nd_q;
    nzero_d    = nzero_q;
    pad_d      = pad_q;
    b1_d       = b1_q;
    b2_d       = b2_q;
    b3_d       = b3_q;
    b4_d       = b4_q;
    len_d      = len_q;
    pos_d      = pos_q;
    ovalid_d   = ovalid_q && !out_ready_i;
    ochar_d    = ochar_q;
    olast_d    = olast_q;
    in_ready_o = 1'b0;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          bin_d   = in_entry_i.mag;
          neg_d   = in_entry_i.neg;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d = {adj_flat[DigitBits-2:0], bin_q[OperandBits-1]};
        bin_d = {bin_q[OperandBits-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == {ConvCntBits{1'b1}}) begin
          state_d = StCount;
        end
      end
      StCount: begin
        nd_d = '0;
        for (int i = 0; i < DigitCount; i++) begin
          if (bcd_q[i] != 4'd0) begin
            nd_d = NdBits'(i + 1);
          end
        end
        state_d = StLen;
      end
      StLen: begin
        nzero_d = (prec_eff > nd_ext) ? prec_eff - nd_ext : '0;
        state_d = StPad;
      end
      StPad: begin
        pad_d   = (width_sat > body) ? width_sat - body : '0;
        state_d = StBound;
      end
      StBound: begin
        b1_d  = lead;
        b2_d  = lead + sign_len;
        b3_d  = lead + sign_len + zeros;
        b4_d  = lead + sign_len + zeros + nd_ext;
        len_d = lead + sign_len + zeros + nd_ext + trail;
        pos_d = '0;
        if ((lead + sign_len + zeros + nd_ext + trail) == '0) begin
          state_d = StIdle;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          olast_d  = pos_q == len_q - LenBits'(1);
          priority if (pos_q < b1_q) begin
            ochar_d = CharSpace;
          end else if (pos_q < b2_q) begin
            ochar_d = sign_char;
          end else if (pos_q < b3_q) begin
            ochar_d = CharZero;
          end else if (pos_q < b4_q) begin
            ochar_d = CharZero | {4'd0, bcd_q[dig_idx[NdBits-1:0]]};
          end else begin
            ochar_d = CharSpace;
          end
          pos_d = pos_q + LenBits'(1);
          if (pos_q == len_q - LenBits'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = ochar_q;
  assign out_last_o  = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      cnt_q    <= '0;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q   <= bin_d;
    bcd_q   <= bcd_d;
    neg_q   <= neg_d;
    nd_q    <= nd_d;
    nzero_q <= nzero_d;
    pad_q   <= pad_d;
    b1_q    <= b1_d;
    b2_q    <= b2_d;
    b3_q    <= b3_d;
    b4_q    <= b4_d;
    len_q   <= len_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the signed decimal formatter top level.
`timescale 1ns / 1ps

module tb_top;
  import sdf_pkg::*;

  localparam int CycleLimit  = 1000000;
  localparam int DrainCycles = 400;
  localparam int HoldCycles  = 400;

  class field_checker;
    typedef struct packed {
      logic [7:0] ch;
      logic       last;
    } char_beat_t;

    char_beat_t        expected_chars[$];
    int                errors;
    int                beat_no;
    logic [1:0]        operand_size;
    logic [6:0]        field_width;
    logic signed [6:0] min_digits;
    logic              zero_pad;
    logic              pad_right;
    logic [1:0]        sign_mode;

    function new();
      errors       = 0;
      beat_no      = 0;
      operand_size = Size32;
      field_width  = 7'd0;
      min_digits   = -7'sd1;
      zero_pad     = 1'b0;
      pad_right    = 1'b0;
      sign_mode    = SignNone;
    endfunction

    function void write_reg(logic [2:0] idx, logic [6:0] data);
      case (idx)
        CfgOperandSize: operand_size = data[1:0];
        CfgFieldWidth:  field_width  = data;
        CfgMinDigits:   min_digits   = data;
        CfgZeroPad:     zero_pad     = data[0];
        CfgPadRight:    pad_right    = data[0];
        CfgSignMode:    sign_mode    = data[1:0];
        default: ;
      endcase
    endfunction

    function void note_operand(logic [63:0] raw);
      logic [63:0] v;
      logic [63:0] mag;
      logic [63:0] rem;
      logic        neg;
      logic        has_sign;
      logic [7:0]  sign_ch;
      logic [7:0]  digs [20];
      logic [7:0]  text [$];
      int          nd;
      int          prec;
      int          nzero;
      int          body;
      int          width;
      int          pad;

      case (operand_size)
        Size8:   v = {{56{raw[7]}}, raw[7:0]};
        Size16:  v = {{48{raw[15]}}, raw[15:0]};
        Size32:  v = {{32{raw[31]}}, raw[31:0]};
        default: v = raw;
      endcase
      neg = v[63];
      mag = neg ? (~v + 64'd1) : v;
      nd  = 0;
      while (mag != 64'd0) begin
        rem      = mag % 64'd10;
        digs[nd] = CharZero + rem[7:0];
        mag      = mag / 64'd10;
        nd++;
      end

      has_sign = 1'b1;
      sign_ch  = CharMinus;
      if (!neg) begin
        if (sign_mode == SignPlus) sign_ch = CharPlus;
        else if (sign_mode == SignSpace) sign_ch = CharSpace;
        else has_sign = 1'b0;
      end

      prec  = (min_digits < 0) ? 1 : int'(min_digits);
      nzero = (prec > nd) ? prec - nd : 0;
      body  = int'(has_sign) + nzero + nd;
      width = (field_width > 7'd64) ? 64 : int'(field_width);
      pad   = (width > body) ? width - body : 0;

      if (pad_right) begin
        if (has_sign) text.push_back(sign_ch);
        repeat (nzero) text.push_back(CharZero);
        for (int i = nd - 1; i >= 0; i--) text.push_back(digs[i]);
        repeat (pad) text.push_back(CharSpace);
      end else if (zero_pad && min_digits < 0) begin
        if (has_sign) text.push_back(sign_ch);
        repeat (pad + nzero) text.push_back(CharZero);
        for (int i = nd - 1; i >= 0; i--) text.push_back(digs[i]);
      end else begin
        repeat (pad) text.push_back(CharSpace);
        if (has_sign) text.push_back(sign_ch);
        repeat (nzero) text.push_back(CharZero);
        for (int i = nd - 1; i >= 0; i--) text.push_back(digs[i]);
      end

      for (int i = 0; i < text.size(); i++)
        expected_chars.push_back('{text[i], i == text.size() - 1});
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH beat %0d: %s", beat_no, msg);
    endtask

    task check_char(logic [7:0] ch, logic last);
      char_beat_t exp_beat;
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char %h last %b", ch, last));
      end else begin
        exp_beat = expected_chars.pop_front();
        if (ch !== exp_beat.ch)
          report($sformatf("char %h, expected %h", ch, exp_beat.ch));
        if (last !== exp_beat.last)
          report($sformatf("last %b, expected %b", last, exp_beat.last));
      end
      beat_no++;
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [6:0]  cfg_data_i;

  field_checker fmt = new();
  int           max_gap = 5;
  int           cycle_count = 0;
  bit           long_hold = 1'b0;

  signed_decimal_formatter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("signed_decimal_formatter_top test failed");
      $finish;
    end
  end

  task automatic write_cfg(input logic [2:0] idx, input logic [6:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    fmt.write_reg(idx, data);
  endtask

  task automatic apply_setting(input logic [1:0] size, input logic [6:0] width,
                               input logic [6:0] prec, input logic zp, input logic la,
                               input logic [1:0] sm);
    write_cfg(CfgOperandSize, {5'($urandom), size});
    write_cfg(CfgFieldWidth, width);
    write_cfg(CfgMinDigits, prec);
    write_cfg(CfgZeroPad, {6'($urandom), zp});
    write_cfg(CfgPadRight, {6'($urandom), la});
    write_cfg(CfgSignMode, {5'($urandom), sm});
    write_cfg(3'd6, 7'($urandom));
    write_cfg(3'd7, 7'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_setting();
    logic [6:0] width;
    logic [6:0] prec;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: width = 7'($urandom_range(0, 12));
      6, 7:             width = 7'($urandom_range(13, 30));
      8:                width = 7'd64;
      default:          width = 7'($urandom_range(65, 127));
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: prec = 7'h7F;
      4, 5, 6:    prec = 7'($urandom_range(0, 8));
      7:          prec = 7'($urandom_range(9, 25));
      8:          prec = 7'd63;
      default:    prec = 7'($urandom_range(64, 126));
    endcase
    apply_setting(2'($urandom_range(0, 3)), width, prec, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
  endtask

  task automatic send_operand(input logic [63:0] raw);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fmt.note_operand(raw);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (fmt.expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_operand();
    logic [63:0] v;
    int          k;
    case ($urandom_range(0, 5))
      0, 1, 2: v = {$urandom, $urandom};
      3: begin
        v = 64'($urandom_range(0, 20));
        if ($urandom_range(0, 1)) v = -v;
      end
      4: begin
        k = $urandom_range(0, 3);
        v = 64'd1 << ((8 << k) - 1);
        case ($urandom_range(0, 2))
          1:       v = v - 64'd1;
          2:       v = ~64'd0;
          default: ;
        endcase
      end
      default: begin
        v = 64'd1;
        k = $urandom_range(0, 19);
        repeat (k) v = v * 64'd10;
        if ($urandom_range(0, 1)) v = v - 64'd1;
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  initial begin
    int hold;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = $urandom_range(0, max_gap);
      if (long_hold) begin
        hold      = HoldCycles;
        long_hold = 1'b0;
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      fmt.check_char(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 64'd0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = 3'd0;
    cfg_data_i    = 7'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults after reset: 32-bit operands, no width, no precision.
    send_operand(64'd0);
    send_operand(64'd1);
    send_operand(64'h0000_0000_FFFF_FFFF);
    send_operand(64'h0000_0000_8000_0000);
    send_operand(64'h0000_0000_7FFF_FFFF);
    send_operand(64'hDEAD_BEEF_0000_0005);
    settle();

    // Zero with precision zero gives nothing; most negative 64-bit value.
    apply_setting(Size64, 7'd0, 7'd0, 1'b0, 1'b0, SignNone);
    send_operand(64'd0);
    send_operand(64'h8000_0000_0000_0000);
    send_operand(64'hFFFF_FFFF_FFFF_FFFF);
    send_operand(64'h7FFF_FFFF_FFFF_FFFF);
    settle();

    apply_setting(Size8, 7'd64, 7'h7F, 1'b1, 1'b1, SignPlus);
    send_operand(64'h80);
    send_operand(64'h7F);
    send_operand(64'h0);
    send_operand(64'h1FF);
    settle();

    // Saturated width, a negative precision other than minus one, sign mode three.
    apply_setting(Size16, 7'd127, 7'h40, 1'b1, 1'b0, 2'd3);
    send_operand(64'h8000);
    send_operand(64'h7FFF);
    send_operand(64'h0);
    send_operand(64'h1234);
    settle();

    // A given precision switches zero padding off.
    apply_setting(Size16, 7'd20, 7'd5, 1'b1, 1'b0, SignSpace);
    send_operand(64'h8000);
    send_operand(64'h7);
    send_operand(64'h0);
    settle();

    apply_setting(Size64, 7'd70, 7'd63, 1'b1, 1'b1, SignPlus);
    send_operand(64'h8000_0000_0000_0000);
    send_operand(64'h0);
    settle();

    apply_setting(Size32, 7'd0, 7'd0, 1'b0, 1'b0, SignPlus);
    send_operand(64'h0);
    settle();

    for (int phase = 0; phase < 10; phase++) begin
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 5;
      random_setting();
      // The receiver stalls for a long stretch while this phase keeps offering operands.
      if (phase == 1) long_hold = 1'b1;
      repeat (30) send_operand(pick_operand());
      settle();
    end

    if (fmt.expected_chars.size() != 0)
      fmt.report($sformatf("%0d chars never arrived", fmt.expected_chars.size()));
    if (fmt.errors == 0)
      $display("signed_decimal_formatter_top test passed");
    else
      $display("signed_decimal_formatter_top test failed");
    $finish;
  end

endmodule
